// ===== rtl/core/wrpt_pkg.sv =====
// shared types and constants for the weighted random pick table
`timescale 1ns / 1ps
package wrpt_pkg;
  localparam int CAPACITY = 64;
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [23:0] WEIGHT_LIMIT_RESET = 24'd10000000;

  localparam logic [2:0] KIND_ADD_NUM   = 3'd0;
  localparam logic [2:0] KIND_ADD_RANGE = 3'd1;
  localparam logic [2:0] KIND_DRAW      = 3'd2;
  localparam logic [2:0] KIND_DRAW_REM  = 3'd3;
  localparam logic [2:0] KIND_CLEAR     = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_ZERO_WT   = 3'd2;
  localparam logic [2:0] ST_OVER_LIM  = 3'd3;
  localparam logic [2:0] ST_MIN_MAX   = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;

  typedef struct packed {
    logic [23:0] cw;
    logic        is_range;
    logic [31:0] low;
    logic [31:0] high;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);
endpackage

// ===== rtl/core/wrpt_ram.sv =====
// generic single write, single read ram with registered read
`timescale 1ns / 1ps
module wrpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/wrpt_mod.sv =====
// iterative restoring modulo unit, one remainder bit per cycle
`timescale 1ns / 1ps
module wrpt_mod (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] rem
);
  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [31:0] rem_r;
  logic [31:0] dvd_r;
  logic [31:0] dvs_r;
  logic [32:0] trial;
  logic [32:0] diff;

  assign trial = {rem_r, dvd_r[31]};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        dvd_r  <= dividend;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= diff[32] ? trial[31:0] : diff[31:0];
        dvd_r <= {dvd_r[30:0], 1'b0};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;
endmodule

// ===== rtl/core/weighted_random_pick_table_top.sv =====
// weighted random pick table: entry store, draw sequencer and removal shifter
// appends, clears and empty draws answer in the cycle after start
// draws scan the entries in order, with a second modulo step for a range entry
// removals shift later entries down; all work runs on one modulo unit
// one item at a time, busy high while a draw runs; the receiver cannot stall
// rst_n synchronous: empties the table, limit back to 10000000
`timescale 1ns / 1ps
module weighted_random_pick_table_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_kind,
  input  logic [23:0]        in_weight,
  input  logic signed [31:0] in_value_low,
  input  logic signed [31:0] in_value_high,
  input  logic [31:0]        in_rand_pick,
  input  logic [31:0]        in_rand_offset,
  input  logic               cfg_we,
  input  logic [23:0]        cfg_wdata,
  output logic               out_strobe,
  output logic signed [31:0] out_value,
  output logic [2:0]         out_status,
  output logic [6:0]         out_entry_count,
  output logic [23:0]        out_total_weight
);
  import wrpt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MOD1_GO, S_MOD1_WAIT, S_RD, S_CMP, S_MOD2_GO, S_MOD2_WAIT,
    S_REM, S_SRD, S_SWR, S_FINISH
  } state_t;

  state_t           state_r;
  logic [23:0]      limit_r;
  logic [CNT_W-1:0] count_r;
  logic [23:0]      total_r;
  logic             remove_r;
  logic [31:0]      pick_r;
  logic [31:0]      offs_r;
  logic [23:0]      key_r;
  logic [IDX_W-1:0] idx_r;
  logic [23:0]      prev_r;
  logic [23:0]      removed_r;
  entry_t           ent_r;
  logic [31:0]      span_r;
  logic [31:0]      value_r;

  logic             out_strobe_r;
  logic [31:0]      out_value_r;
  logic [2:0]       out_status_r;
  logic [CNT_W-1:0] out_count_r;
  logic [23:0]      out_total_r;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  entry_t           ram_rdata;

  logic             mod_go;
  logic [31:0]      mod_dvd;
  logic [31:0]      mod_dvs;
  logic             mod_done;
  logic [31:0]      mod_rem;

  logic [24:0]      add_sum;
  logic             accept;
  logic [CNT_W-1:0] idx_next;
  logic [31:0]      rd_span;
  logic [2:0]       add_status;

  assign accept   = start && (state_r == S_IDLE);
  assign add_sum  = {1'b0, total_r} + {1'b0, in_weight};
  assign idx_next = {1'b0, idx_r} + 1'b1;
  assign rd_span  = ram_rdata.high - ram_rdata.low + 32'd1;

  always_comb begin
    if (in_weight == 24'd0) begin
      add_status = ST_ZERO_WT;
    end else if (in_kind == KIND_ADD_RANGE && (in_value_high < in_value_low)) begin
      add_status = ST_MIN_MAX;
    end else if (add_sum > {1'b0, limit_r}) begin
      add_status = ST_OVER_LIM;
    end else if (count_r >= CNT_W'(CAPACITY)) begin
      add_status = ST_FULL;
    end else begin
      add_status = ST_OK;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = ram_rdata;
    ram_raddr = idx_r;
    if (state_r == S_IDLE) begin
      ram_waddr          = count_r[IDX_W-1:0];
      ram_wdata.cw       = add_sum[23:0];
      ram_wdata.is_range = (in_kind == KIND_ADD_RANGE);
      ram_wdata.low      = in_value_low;
      ram_wdata.high     = (in_kind == KIND_ADD_RANGE) ? in_value_high : 32'd0;
      ram_we = accept && (in_kind == KIND_ADD_NUM || in_kind == KIND_ADD_RANGE)
               && (add_status == ST_OK);
    end else if (state_r == S_SRD) begin
      ram_raddr = idx_next[IDX_W-1:0];
    end else if (state_r == S_SWR) begin
      ram_we       = 1'b1;
      ram_wdata.cw = ram_rdata.cw - removed_r;
    end
  end

  assign mod_go  = (state_r == S_MOD1_GO) || (state_r == S_MOD2_GO);
  assign mod_dvd = (state_r == S_MOD1_GO) ? pick_r : offs_r;
  assign mod_dvs = (state_r == S_MOD1_GO) ? {8'd0, total_r} : span_r;

  wrpt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  wrpt_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (mod_go),
    .dividend (mod_dvd),
    .divisor  (mod_dvs),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      limit_r      <= WEIGHT_LIMIT_RESET;
      count_r      <= '0;
      total_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            remove_r     <= (in_kind == KIND_DRAW_REM);
            pick_r       <= in_rand_pick;
            offs_r       <= in_rand_offset;
            out_value_r  <= '0;
            out_status_r <= ST_OK;
            out_count_r  <= count_r;
            out_total_r  <= total_r;
            if (in_kind == KIND_ADD_NUM || in_kind == KIND_ADD_RANGE) begin
              out_strobe_r <= 1'b1;
              out_status_r <= add_status;
              if (add_status == ST_OK) begin
                count_r     <= count_r + 1'b1;
                total_r     <= add_sum[23:0];
                out_count_r <= count_r + 1'b1;
                out_total_r <= add_sum[23:0];
              end
            end else if (in_kind == KIND_DRAW || in_kind == KIND_DRAW_REM) begin
              if (count_r == '0 || total_r == 24'd0) begin
                out_strobe_r <= 1'b1;
                out_status_r <= ST_EMPTY;
              end else begin
                state_r <= S_MOD1_GO;
              end
            end else if (in_kind == KIND_CLEAR) begin
              out_strobe_r <= 1'b1;
              count_r      <= '0;
              total_r      <= '0;
              out_count_r  <= '0;
              out_total_r  <= '0;
            end else begin
              out_strobe_r <= 1'b1;
            end
          end
        end
        S_MOD1_GO: begin
          state_r <= S_MOD1_WAIT;
        end
        S_MOD1_WAIT: begin
          if (mod_done) begin
            key_r   <= mod_rem[23:0] + 24'd1;
            idx_r   <= '0;
            prev_r  <= '0;
            state_r <= S_RD;
          end
        end
        S_RD: begin
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (ram_rdata.cw >= key_r || idx_next == count_r) begin
            ent_r  <= ram_rdata;
            span_r <= rd_span;
            if (ram_rdata.is_range && rd_span != 32'd0) begin
              state_r <= S_MOD2_GO;
            end else begin
              value_r <= ram_rdata.is_range ? ram_rdata.low + offs_r : ram_rdata.low;
              state_r <= S_REM;
            end
          end else begin
            prev_r  <= ram_rdata.cw;
            idx_r   <= idx_next[IDX_W-1:0];
            state_r <= S_RD;
          end
        end
        S_MOD2_GO: begin
          state_r <= S_MOD2_WAIT;
        end
        S_MOD2_WAIT: begin
          if (mod_done) begin
            value_r <= ent_r.low + mod_rem;
            state_r <= S_REM;
          end
        end
        S_REM: begin
          removed_r <= ent_r.cw - prev_r;
          if (remove_r && idx_next < count_r) begin
            state_r <= S_SRD;
          end else begin
            state_r <= S_FINISH;
          end
        end
        S_SRD: begin
          state_r <= S_SWR;
        end
        S_SWR: begin
          idx_r <= idx_next[IDX_W-1:0];
          if (idx_next + 1'b1 < count_r) begin
            state_r <= S_SRD;
          end else begin
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          out_strobe_r <= 1'b1;
          out_value_r  <= value_r;
          out_status_r <= ST_OK;
          if (remove_r) begin
            count_r     <= count_r - 1'b1;
            total_r     <= total_r - removed_r;
            out_count_r <= count_r - 1'b1;
            out_total_r <= total_r - removed_r;
          end else begin
            out_count_r <= count_r;
            out_total_r <= total_r;
          end
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy             = (state_r != S_IDLE);
  assign out_strobe       = out_strobe_r;
  assign out_value        = out_value_r;
  assign out_status       = out_status_r;
  assign out_entry_count  = 7'(out_count_r);
  assign out_total_weight = out_total_r;

`ifndef SYNTH
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (total_r == 24'd0))
    else $error("empty table with nonzero total");

  a_draw_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_kind == KIND_DRAW || in_kind == KIND_DRAW_REM) && count_r != '0)
    |=> (busy && !out_strobe))
    else $error("draw did not start the sequencer");

  a_finish_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH) |=> (out_strobe && !busy))
    else $error("finished draw gave no result");
`endif
endmodule
